// ----- hw/rtl/b32c_pkg.sv -----
// shared types, constants and alphabet functions for the base32 stream codec
package b32c_pkg;

   localparam logic [4:0] ALPHA_SPLIT = 5'd26;
   localparam logic [7:0] CHAR_A      = 8'h61;
   localparam logic [7:0] CHAR_TWO    = 8'h32;
   // offset that maps values 26..31 onto '2'..'7'
   localparam logic [7:0] DIGIT_BIAS  = CHAR_TWO - {3'b000, ALPHA_SPLIT};

   localparam logic MODE_ENCODE = 1'b0;
   localparam logic MODE_DECODE = 1'b1;

   localparam int RESULTS_MAX = 3;

   // one queued work entry: up to three results caused by a single input item
   typedef struct packed {
      logic [RESULTS_MAX-1:0][7:0] sym;
      logic [1:0]                  last_idx;
      logic                        eom;
      logic                        no_data;
   } b32c_entry_type;

   typedef struct packed {
      logic       mode;
      logic [2:0] pend_cnt;
   } b32c_status_type;

   function automatic logic [7:0] to_char(input logic [4:0] v);
      logic [7:0] ch;
      if (v < ALPHA_SPLIT) begin
         ch = CHAR_A + {3'b000, v};
      end else begin
         ch = DIGIT_BIAS + {3'b000, v};
      end
      return ch;
   endfunction

   function automatic logic [4:0] from_char(input logic [7:0] c);
      logic [7:0] diff;
      if (c >= CHAR_A) begin
         diff = c - CHAR_A;
      end else begin
         diff = c - DIGIT_BIAS;
      end
      return diff[4:0];
   endfunction

endpackage

// ----- hw/rtl/base32_stream_codec_core.sv -----
// top level of the streaming base32 encoder/decoder
//
//  channel  direction  handshake          payload
//  req      in         push / full        req_data[7:0], req_end_of_message
//  rsp      out        pop / empty        rsp_symbol[7:0], rsp_last, rsp_no_data
//  csr      in         valid / ready      csr_mode
//
// an item is accepted every cycle while the entry queue has room; the result side
// delivers one result per cycle while rsp_pop keeps up, so encode yields one or two
// results per byte (three on a flushing byte) and decode at most one per character.
// results reach the ports through a queue slot and then the output register.
// synchronous reset clears mode to encode, the pending bits, queue fill and pointers and output valid.
// a stalled rsp side fills the queue and then raises req_full; csr_ready is always high.
module base32_stream_codec_core #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_data,
   input  logic       req_end_of_message,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_symbol,
   output logic       rsp_last,
   output logic       rsp_no_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_mode
);
   import b32c_pkg::*;

   logic            req_accept;
   logic            cfg_we;
   logic            q_push, q_pop, q_full, q_empty;
   b32c_entry_type  q_in_entry, q_head;
   b32c_status_type front_status;

   assign csr_ready  = 1'b1;
   assign cfg_we     = csr_valid && csr_ready;
   assign req_full   = q_full;
   assign req_accept = req_push && !q_full;

   b32c_front u_front (
      .clock      (clock),
      .reset      (reset),
      .item_valid (req_accept),
      .item_data  (req_data),
      .item_eom   (req_end_of_message),
      .cfg_we     (cfg_we),
      .cfg_mode   (csr_mode),
      .q_push     (q_push),
      .q_entry    (q_in_entry),
      .status     (front_status)
   );

   b32c_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_in_entry),
      .pop        (q_pop),
      .head_entry (q_head),
      .full       (q_full),
      .empty      (q_empty)
   );

   b32c_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_empty     (q_empty),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .rsp_pop     (rsp_pop),
      .rsp_empty   (rsp_empty),
      .rsp_symbol  (rsp_symbol),
      .rsp_last    (rsp_last),
      .rsp_no_data (rsp_no_data)
   );

`ifndef NO_ASSERTIONS
   a_reset_empties: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("result side not empty after reset");

   a_eom_flushes: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_end_of_message) |=> (front_status.pend_cnt == 3'd0))
      else $error("pending bits left after end of message");

   a_cfg_clears: assert property (@(posedge clock) disable iff (reset)
      cfg_we |=> (front_status.pend_cnt == 3'd0))
      else $error("pending bits left after mode write");

   a_encode_pending: assert property (@(posedge clock) disable iff (reset)
      (front_status.mode == MODE_ENCODE) |-> (front_status.pend_cnt < 3'd5))
      else $error("encode holds a full group unsent");
`endif

endmodule

// ----- hw/rtl/b32c_front.sv -----
// front end: bit accumulator, encode/decode of one item into a work entry
module b32c_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     item_valid,
   input  logic [7:0]               item_data,
   input  logic                     item_eom,
   input  logic                     cfg_we,
   input  logic                     cfg_mode,
   output logic                     q_push,
   output b32c_pkg::b32c_entry_type q_entry,
   output b32c_pkg::b32c_status_type status
);
   import b32c_pkg::*;

   logic       mode_ff, mode_in;
   logic [6:0] acc_ff, acc_in;
   logic [2:0] cnt_ff, cnt_in;

   // encode path
   logic [11:0] enc_acc;
   logic [3:0]  enc_cnt;
   logic [3:0]  enc_sh0, enc_sh1;
   logic        enc_two;
   logic [2:0]  enc_rem;
   logic        enc_tail_en;
   logic [2:0]  enc_tail_sh;
   logic [11:0] enc_tail_word;
   logic [11:0] enc_mask;
   logic [7:0]  enc_s0, enc_s1, enc_tail;

   // decode path
   logic [4:0]  dec_val;
   logic [11:0] dec_acc;
   logic [3:0]  dec_cnt;
   logic        dec_emit;
   logic [3:0]  dec_sh;
   logic [2:0]  dec_rem;
   logic [11:0] dec_mask;
   logic [7:0]  dec_byte;

   always_comb begin
      enc_acc       = {acc_ff[3:0], item_data};
      enc_cnt       = {1'b0, cnt_ff} + 4'd8;
      enc_sh0       = enc_cnt - 4'd5;
      enc_sh1       = enc_cnt - 4'd10;
      enc_two       = enc_cnt >= 4'd10;
      enc_rem       = enc_two ? enc_sh1[2:0] : enc_sh0[2:0];
      enc_tail_en   = item_eom && (enc_rem != 3'd0);
      enc_tail_sh   = 3'd5 - enc_rem;
      enc_tail_word = enc_acc << enc_tail_sh;
      enc_mask      = (12'd1 << enc_rem) - 12'd1;
      enc_s0        = to_char(5'(enc_acc >> enc_sh0));
      enc_s1        = to_char(5'(enc_acc >> enc_sh1));
      enc_tail      = to_char(enc_tail_word[4:0]);

      dec_val  = from_char(item_data);
      dec_acc  = {acc_ff, dec_val};
      dec_cnt  = {1'b0, cnt_ff} + 4'd5;
      dec_emit = dec_cnt >= 4'd8;
      dec_sh   = dec_cnt - 4'd8;
      dec_rem  = dec_emit ? dec_sh[2:0] : dec_cnt[2:0];
      dec_mask = (12'd1 << dec_rem) - 12'd1;
      dec_byte = 8'(dec_acc >> dec_sh);
   end

   always_comb begin
      q_entry     = '0;
      q_entry.eom = item_eom;
      if (mode_ff == MODE_ENCODE) begin
         q_entry.sym[0] = enc_s0;
         q_entry.sym[1] = enc_two ? enc_s1 : enc_tail;
         q_entry.sym[2] = enc_tail;
         if (enc_two) begin
            q_entry.last_idx = enc_tail_en ? 2'd2 : 2'd1;
         end else begin
            q_entry.last_idx = enc_tail_en ? 2'd1 : 2'd0;
         end
         q_push = item_valid;
      end else begin
         q_entry.sym[0]  = dec_emit ? dec_byte : 8'h00;
         q_entry.no_data = !dec_emit;
         q_push          = item_valid && (dec_emit || item_eom);
      end
   end

   always_comb begin
      mode_in = mode_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      if (cfg_we) begin
         mode_in = cfg_mode;
         acc_in  = '0;
         cnt_in  = '0;
      end else if (item_valid) begin
         if (item_eom) begin
            acc_in = '0;
            cnt_in = '0;
         end else if (mode_ff == MODE_ENCODE) begin
            acc_in = 7'(enc_acc & enc_mask);
            cnt_in = enc_rem;
         end else begin
            acc_in = 7'(dec_acc & dec_mask);
            cnt_in = dec_rem;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_ENCODE;
         acc_ff  <= '0;
         cnt_ff  <= '0;
      end else begin
         mode_ff <= mode_in;
         acc_ff  <= acc_in;
         cnt_ff  <= cnt_in;
      end
   end

   assign status.mode     = mode_ff;
   assign status.pend_cnt = cnt_ff;

endmodule

// ----- hw/rtl/b32c_queue.sv -----
// short queue of work entries between the front and back ends
module b32c_queue #(
   parameter int DEPTH = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  b32c_pkg::b32c_entry_type push_entry,
   input  logic                     pop,
   output b32c_pkg::b32c_entry_type head_entry,
   output logic                     full,
   output logic                     empty
);
   import b32c_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   b32c_entry_type   slot_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [AW:0]      fill_ff, fill_in;
   logic             do_push, do_pop;

   assign full       = fill_ff == (AW+1)'(DEPTH);
   assign empty      = fill_ff == '0;
   assign do_push    = push && !full;
   assign do_pop     = pop && !empty;
   assign head_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ----- hw/rtl/b32c_back.sv -----
// back end: walks the results of the head entry into the output register
module b32c_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_empty,
   input  b32c_pkg::b32c_entry_type q_head,
   output logic                     q_pop,
   input  logic                     rsp_pop,
   output logic                     rsp_empty,
   output logic [7:0]               rsp_symbol,
   output logic                     rsp_last,
   output logic                     rsp_no_data
);
   import b32c_pkg::*;

   logic       out_valid_ff, out_valid_in;
   logic [1:0] idx_ff, idx_in;
   logic [7:0] sym_ff;
   logic       last_ff;
   logic       no_data_ff;
   logic       load, take, at_end;
   logic [7:0] sel_sym;

   assign load   = !out_valid_ff || rsp_pop;
   assign take   = load && !q_empty;
   assign at_end = idx_ff == q_head.last_idx;
   assign q_pop  = take && at_end;

   always_comb begin
      case (idx_ff)
         2'd0:    sel_sym = q_head.sym[0];
         2'd1:    sel_sym = q_head.sym[1];
         default: sel_sym = q_head.sym[2];
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      idx_in       = idx_ff;
      if (take) begin
         out_valid_in = 1'b1;
         idx_in       = at_end ? 2'd0 : idx_ff + 2'd1;
      end else if (load) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         sym_ff     <= sel_sym;
         last_ff    <= at_end && q_head.eom;
         no_data_ff <= q_head.no_data;
      end
   end

   assign rsp_empty   = !out_valid_ff;
   assign rsp_symbol  = sym_ff;
   assign rsp_last    = last_ff;
   assign rsp_no_data = no_data_ff;

endmodule
